// ===== rtl/i2cseq_pkg.sv =====
// Shared types and codes for the I2C transfer event sequencer.
package i2cseq_pkg;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_EVENT = 2'd0;
  localparam mode_t MODE_START = 2'd1;
  localparam mode_t MODE_LOAD  = 2'd2;
  localparam mode_t MODE_READ  = 2'd3;

  // Bit positions in the controller event flags.
  localparam int EV_SB    = 0;
  localparam int EV_ADDR  = 1;
  localparam int EV_TXE   = 2;
  localparam int EV_RXNE  = 3;
  localparam int EV_STOPF = 4;
  localparam int EV_TRA   = 5;
  localparam int EV_MSL   = 6;

  typedef logic [1:0] ack_t;
  localparam ack_t ACK_KEEP    = 2'd0;
  localparam ack_t ACK_ENABLE  = 2'd1;
  localparam ack_t ACK_DISABLE = 2'd2;

  typedef logic [2:0] note_t;
  localparam note_t NOTE_NONE = 3'd0;
  localparam note_t NOTE_MTX  = 3'd1;
  localparam note_t NOTE_MRX  = 3'd2;
  localparam note_t NOTE_SRX  = 3'd3;
  localparam note_t NOTE_STX  = 3'd4;

  typedef logic cfg_index_t;
  localparam cfg_index_t CFG_OWN_ADDRESS = 1'b0;
  localparam cfg_index_t CFG_SLAVE_LENGTH = 1'b1;

  localparam int CFG_DATA_W = 7;

  typedef struct packed {
    mode_t       mode;
    logic [6:0]  event_flags;
    logic [3:0]  error_flags;
    logic [7:0]  data_byte;
    logic        read_not_write;
    logic [6:0]  target_address;
    logic [5:0]  byte_count;
    logic        store_select;
    logic [4:0]  entry_index;
  } in_item_t;

  typedef struct packed {
    logic        write_data_reg;
    logic [7:0]  data_reg_value;
    logic        stop_request;
    logic        start_request;
    ack_t        ack_action;
    logic        clear_control;
    logic [3:0]  error_report;
    note_t       notify;
    logic [7:0]  read_value;
    logic        master_active;
  } out_item_t;

  // Where the registered store read data lands in the result.
  typedef struct packed {
    logic to_dreg;
    logic to_rval;
    logic sel;
  } ram_use_t;

endpackage

// ===== rtl/i2cseq_if.sv =====
// Valid/ready channel interfaces for sequencer input items and result items.
interface i2cseq_in_if;
  import i2cseq_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface i2cseq_out_if;
  import i2cseq_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/i2cseq_ram.sv =====
// Generic single-port RAM with write enable, read enable and registered read data.
module i2cseq_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/i2c_transfer_event_sequencer.sv =====
// An accepted transfer's result passes through stage 1, then the output register.
// One item per cycle unless the output stalls; the registered RAM read sets two stages.
// A result waiting at the output does not block input while the middle stage is free.
// Reset (rst_ni low, asynchronous) clears mode, target, lengths, position and valids.
// Byte stores lack reset; the user must have an entry loaded before it reads back.
module i2c_transfer_event_sequencer #(
  parameter int STORE_DEPTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  i2cseq_pkg::cfg_index_t              cfg_index_i,
  input  logic [i2cseq_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  i2cseq_in_if.sink                           in_i,
  i2cseq_out_if.source                        out_o
);
  import i2cseq_pkg::*;

  // Index width of one store; the position and entry index are compared against
  // the depth at eight bits, so out-of-range accesses never reach the RAMs.
  localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [7:0] DEPTH8 = 8'(STORE_DEPTH);

  // Sequencer state. The position wraps at 256 like the byte counter it models.
  logic       master_q, master_d;
  logic       dir_q, dir_d;
  logic [6:0] target_q, target_d;
  logic [5:0] mlen_q, mlen_d;
  logic [7:0] pos_q, pos_d;
  logic [5:0] slen_q;

  // Pipeline: stage 1 waits for the RAM read data, stage 2 is the output register.
  logic      s1_v_q, s2_v_q;
  out_item_t s1_res_q, s2_res_q;
  ram_use_t  s1_use_q;
  logic      s1_adv, in_fire;

  out_item_t res;
  ram_use_t  use_r;
  out_item_t merged;

  logic             m_we, m_re, s_we, s_re;
  logic [IDX_W-1:0] m_addr, s_addr;
  logic [7:0]       m_rdata, s_rdata, rd_byte;

  in_item_t   p;
  logic [7:0] idx8;
  logic [8:0] pos_plus;
  logic [7:0] pos_inc;
  logic       idx_hit, pos_hit;
  logic       sb, addr_ev, txe, rxne, stopf, tra, msl;

  assign p        = in_i.payload;
  assign idx8     = {3'b000, p.entry_index};
  assign pos_plus = {1'b0, pos_q} + 9'd1;
  assign pos_inc  = pos_plus[7:0];
  assign idx_hit  = idx8 < DEPTH8;
  assign pos_hit  = pos_q < DEPTH8;

  assign sb      = p.event_flags[EV_SB];
  assign addr_ev = p.event_flags[EV_ADDR];
  assign txe     = p.event_flags[EV_TXE];
  assign rxne    = p.event_flags[EV_RXNE];
  assign stopf   = p.event_flags[EV_STOPF];
  assign tra     = p.event_flags[EV_TRA];
  assign msl     = p.event_flags[EV_MSL];

  // Handshake: stage 1 advances when the output register is free or being drained.
  assign s1_adv     = !s2_v_q || out_o.ready;
  assign in_i.ready = !s1_v_q || s1_adv;
  assign in_fire    = in_i.valid && in_i.ready;

  // Item decode. All control results and state updates are settled here; only
  // the store byte itself comes from the RAM's registered read data.
  always_comb begin
    res      = '0;
    use_r    = '0;
    m_we     = 1'b0;
    m_re     = 1'b0;
    s_we     = 1'b0;
    s_re     = 1'b0;
    m_addr   = pos_q[IDX_W-1:0];
    s_addr   = pos_q[IDX_W-1:0];
    master_d = master_q;
    dir_d    = dir_q;
    target_d = target_q;
    mlen_d   = mlen_q;
    pos_d    = pos_q;

    unique case (p.mode)
      MODE_START: begin
        dir_d             = p.read_not_write;
        target_d          = p.target_address;
        pos_d             = 8'd0;
        mlen_d            = p.byte_count;
        master_d          = 1'b1;
        res.ack_action    = ACK_ENABLE;
        res.start_request = 1'b1;
      end
      MODE_LOAD: begin
        m_addr = idx8[IDX_W-1:0];
        s_addr = idx8[IDX_W-1:0];
        if (idx_hit) begin
          s_we = p.store_select;
          m_we = !p.store_select;
        end
      end
      MODE_READ: begin
        m_addr = idx8[IDX_W-1:0];
        s_addr = idx8[IDX_W-1:0];
        if (idx_hit) begin
          s_re          = p.store_select;
          m_re          = !p.store_select;
          use_r.to_rval = 1'b1;
          use_r.sel     = p.store_select;
        end
      end
      MODE_EVENT: begin
        if (master_q) begin
          if (sb) begin
            res.write_data_reg = 1'b1;
            res.data_reg_value = {target_q, dir_q};
          end else if (addr_ev) begin
            pos_d = 8'd0;
          end else if (tra) begin
            if (txe) begin
              res.write_data_reg = 1'b1;
              m_re               = pos_hit;
              use_r.to_dreg      = pos_hit;
              pos_d              = pos_inc;
              if (pos_inc == {2'b00, mlen_q}) begin
                res.stop_request = 1'b1;
                res.notify       = NOTE_MTX;
              end
            end
          end else if (rxne) begin
            m_we = pos_hit && (pos_q < {2'b00, mlen_q});
            // The last expected byte is the one whose successor equals the length.
            if (pos_plus == {3'b000, mlen_q}) begin
              res.ack_action   = ACK_DISABLE;
              res.stop_request = 1'b1;
              res.notify       = NOTE_MRX;
            end else if (pos_q >= {2'b00, mlen_q}) begin
              master_d       = 1'b0;
              res.ack_action = ACK_ENABLE;
            end
            pos_d = pos_inc;
          end
        end else begin
          if (addr_ev) begin
            res.ack_action = ACK_ENABLE;
            pos_d          = 8'd0;
          end else if (rxne) begin
            res.ack_action = ACK_ENABLE;
            if (pos_q < {2'b00, slen_q}) begin
              s_we  = pos_hit;
              pos_d = pos_inc;
              if (pos_inc == {2'b00, slen_q}) begin
                res.notify = NOTE_SRX;
              end
            end
          end else if (txe) begin
            res.write_data_reg = 1'b1;
            // Past the slave length the data register gets zero.
            if (pos_q < {2'b00, slen_q}) begin
              s_re          = pos_hit;
              use_r.to_dreg = pos_hit;
              use_r.sel     = 1'b1;
              pos_d         = pos_inc;
              if (pos_inc == {2'b00, slen_q}) begin
                res.notify = NOTE_STX;
              end
            end
          end
        end

        if (p.error_flags != 4'd0) begin
          res.error_report = p.error_flags;
          if (msl) begin
            res.stop_request = 1'b1;
          end
        end
        res.clear_control = stopf;
      end
      default: begin
      end
    endcase

    res.master_active = master_d;
  end

  // Both stores use one RAM each; an item touches at most one entry, and a read
  // in the cycle after a write to the same entry sees the new byte.
  i2cseq_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH),
    .ADDR_W(IDX_W)
  ) u_master_store (
    .clk_i  (clk_i),
    .we_i   (m_we && in_fire),
    .re_i   (m_re && in_fire),
    .addr_i (m_addr),
    .wdata_i(p.data_byte),
    .rdata_o(m_rdata)
  );

  i2cseq_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH),
    .ADDR_W(IDX_W)
  ) u_slave_store (
    .clk_i  (clk_i),
    .we_i   (s_we && in_fire),
    .re_i   (s_re && in_fire),
    .addr_i (s_addr),
    .wdata_i(p.data_byte),
    .rdata_o(s_rdata)
  );

  // A configuration write always drops back to slave mode. The own address is
  // not needed by any result, so only the slave length is kept.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_q <= 1'b0;
      dir_q    <= 1'b0;
      target_q <= '0;
      mlen_q   <= '0;
      pos_q    <= '0;
      slen_q   <= '0;
    end else if (cfg_we_i) begin
      master_q <= 1'b0;
      if (cfg_index_i == CFG_SLAVE_LENGTH) begin
        slen_q <= cfg_wdata_i[5:0];
      end
    end else if (in_fire) begin
      master_q <= master_d;
      dir_q    <= dir_d;
      target_q <= target_d;
      mlen_q   <= mlen_d;
      pos_q    <= pos_d;
    end
  end

  // Stage 1 holds its RAM read data steady while stalled, since no new read is
  // issued until it moves on.
  always_comb begin
    rd_byte = s1_use_q.sel ? s_rdata : m_rdata;
    merged  = s1_res_q;
    if (s1_use_q.to_dreg) begin
      merged.data_reg_value = rd_byte;
    end
    if (s1_use_q.to_rval) begin
      merged.read_value = rd_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_res_q <= res;
      s1_use_q <= use_r;
    end
    if (s1_adv && s1_v_q) begin
      s2_res_q <= merged;
    end
  end

  assign out_o.valid   = s2_v_q;
  assign out_o.payload = s2_res_q;

`ifndef SYNTHESIS
  // A stalled middle stage must not see its RAM data overwritten by a new read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !s1_adv) |-> !(in_fire && (m_re || s_re)))
    else $error("store read issued while stage 1 is stalled");

  // A start request enters master mode and is carried into stage 1.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && p.mode == MODE_START) |=>
      (s1_v_q && s1_res_q.start_request && s1_res_q.master_active && master_q))
    else $error("start request not reflected in stage 1");

  // Master completion notices only arise in master mode, slave ones only in slave mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && (s1_res_q.notify == NOTE_MTX || s1_res_q.notify == NOTE_MRX))
      |-> s1_res_q.master_active)
    else $error("master notice without master mode");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && (s1_res_q.notify == NOTE_SRX || s1_res_q.notify == NOTE_STX))
      |-> !s1_res_q.master_active)
    else $error("slave notice in master mode");

  // A store byte lands in at most one result field.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |-> !(s1_use_q.to_dreg && s1_use_q.to_rval))
    else $error("store read routed to two result fields");
`endif

endmodule

// ===== sim/i2cseq_checker.sv =====
// Checker for the I2C transfer event sequencer: predicts every result and compares it.
`timescale 1ns / 1ps
module i2cseq_checker
  import i2cseq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  cfg_index_t            cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  i2cseq_in_if                  in_ch,
  i2cseq_out_if                 out_ch,
  output int                    mismatches_o,
  output int                    pending_o
);

  localparam int STORE_DEPTH = 32;

  // Own address is held only; it never changes a result.
  logic [6:0] own_addr_q;
  logic [5:0] slave_len_q;
  logic       master_q;
  logic       dir_read_q;
  logic [6:0] target_q;
  logic [5:0] master_len_q;
  logic [7:0] pos_q;
  logic [7:0] master_bytes [STORE_DEPTH];
  logic [7:0] slave_bytes [STORE_DEPTH];

  out_item_t actions_due [$];
  out_item_t predicted;
  out_item_t wanted;

  function automatic logic [7:0] store_byte(input logic slave_side, input logic [7:0] idx);
    if (idx >= STORE_DEPTH) return 8'h00;
    return slave_side ? slave_bytes[idx[4:0]] : master_bytes[idx[4:0]];
  endfunction

  task automatic store_write(input logic slave_side, input logic [7:0] idx,
                             input logic [7:0] value);
    if (idx < STORE_DEPTH) begin
      if (slave_side) slave_bytes[idx[4:0]] = value;
      else master_bytes[idx[4:0]] = value;
    end
  endtask

  // Bus actions for one input item; advances the sequencer state.
  task automatic predict_actions(input in_item_t it, output out_item_t act);
    logic [6:0] ev;
    logic [7:0] mlen;
    logic [7:0] slen;
    act  = '0;
    ev   = it.event_flags;
    mlen = {2'b00, master_len_q};
    slen = {2'b00, slave_len_q};
    case (it.mode)
      MODE_START: begin
        dir_read_q        = it.read_not_write;
        target_q          = it.target_address;
        pos_q             = '0;
        master_len_q      = it.byte_count;
        master_q          = 1'b1;
        act.ack_action    = ACK_ENABLE;
        act.start_request = 1'b1;
      end
      MODE_LOAD: store_write(it.store_select, {3'b000, it.entry_index}, it.data_byte);
      MODE_READ: act.read_value = store_byte(it.store_select, {3'b000, it.entry_index});
      MODE_EVENT: begin
        if (master_q) begin
          if (ev[EV_SB]) begin
            act.write_data_reg = 1'b1;
            act.data_reg_value = {target_q, dir_read_q};
          end else if (ev[EV_ADDR]) begin
            pos_q = '0;
          end else if (ev[EV_TRA]) begin
            if (ev[EV_TXE]) begin
              act.write_data_reg = 1'b1;
              act.data_reg_value = store_byte(1'b0, pos_q);
              pos_q = pos_q + 8'd1;
              if (pos_q == mlen) begin
                act.stop_request = 1'b1;
                act.notify       = NOTE_MTX;
              end
            end
          end else if (ev[EV_RXNE]) begin
            if (pos_q < mlen) store_write(1'b0, pos_q, it.data_byte);
            if (mlen != 8'd0 && pos_q == mlen - 8'd1) begin
              act.ack_action   = ACK_DISABLE;
              act.stop_request = 1'b1;
              act.notify       = NOTE_MRX;
            end else if (pos_q >= mlen) begin
              master_q       = 1'b0;
              act.ack_action = ACK_ENABLE;
            end
            pos_q = pos_q + 8'd1;
          end
        end else begin
          if (ev[EV_ADDR]) begin
            act.ack_action = ACK_ENABLE;
            pos_q          = '0;
          end else if (ev[EV_RXNE]) begin
            act.ack_action = ACK_ENABLE;
            if (pos_q < slen) begin
              store_write(1'b1, pos_q, it.data_byte);
              pos_q = pos_q + 8'd1;
              if (pos_q == slen) act.notify = NOTE_SRX;
            end
          end else if (ev[EV_TXE]) begin
            act.write_data_reg = 1'b1;
            if (pos_q < slen) begin
              act.data_reg_value = store_byte(1'b1, pos_q);
              pos_q = pos_q + 8'd1;
              if (pos_q == slen) act.notify = NOTE_STX;
            end
          end
        end
        if (it.error_flags != 4'd0) begin
          act.error_report = it.error_flags;
          if (ev[EV_MSL]) act.stop_request = 1'b1;
        end
        if (ev[EV_STOPF]) act.clear_control = 1'b1;
      end
    endcase
    act.master_active = master_q;
  endtask

  task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      mismatches_o++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q   = '0;
      slave_len_q  = '0;
      master_q     = 1'b0;
      dir_read_q   = 1'b0;
      target_q     = '0;
      master_len_q = '0;
      pos_q        = '0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        master_bytes[i] = '0;
        slave_bytes[i]  = '0;
      end
      actions_due.delete();
      mismatches_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_OWN_ADDRESS:  own_addr_q = cfg_wdata_i;
          CFG_SLAVE_LENGTH: slave_len_q = cfg_wdata_i[5:0];
        endcase
        master_q = 1'b0;
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_actions(in_ch.payload, predicted);
        actions_due.push_back(predicted);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (actions_due.size() == 0) begin
          mismatches_o++;
          $display("%0t: expected no result, got %h", $time, out_ch.payload);
        end else begin
          wanted = actions_due.pop_front();
          check_field("write_data_reg", 8'(wanted.write_data_reg),
                      8'(out_ch.payload.write_data_reg));
          check_field("data_reg_value", wanted.data_reg_value, out_ch.payload.data_reg_value);
          check_field("stop_request", 8'(wanted.stop_request), 8'(out_ch.payload.stop_request));
          check_field("start_request", 8'(wanted.start_request),
                      8'(out_ch.payload.start_request));
          check_field("ack_action", 8'(wanted.ack_action), 8'(out_ch.payload.ack_action));
          check_field("clear_control", 8'(wanted.clear_control),
                      8'(out_ch.payload.clear_control));
          check_field("error_report", 8'(wanted.error_report), 8'(out_ch.payload.error_report));
          check_field("notify", 8'(wanted.notify), 8'(out_ch.payload.notify));
          check_field("read_value", wanted.read_value, out_ch.payload.read_value);
          check_field("master_active", 8'(wanted.master_active),
                      8'(out_ch.payload.master_active));
        end
      end
      pending_o = actions_due.size();
    end
  end

endmodule

// ===== sim/i2c_transfer_event_sequencer_tb.sv =====
// Testbench top: drives items and configuration into the sequencer and gives the verdict.
`timescale 1ns / 1ps
module i2c_transfer_event_sequencer_tb;
  import i2cseq_pkg::*;

  // Far above the slowest correct run, even with both sides throttled.
  localparam int CYCLE_LIMIT     = 200000;
  localparam int ITEMS_PER_PHASE = 370;

  // Event flag masks built from the package bit positions.
  localparam logic [6:0] F_SB    = 7'd1 << EV_SB;
  localparam logic [6:0] F_ADDR  = 7'd1 << EV_ADDR;
  localparam logic [6:0] F_TXE   = 7'd1 << EV_TXE;
  localparam logic [6:0] F_RXNE  = 7'd1 << EV_RXNE;
  localparam logic [6:0] F_STOPF = 7'd1 << EV_STOPF;
  localparam logic [6:0] F_TRA   = 7'd1 << EV_TRA;
  localparam logic [6:0] F_MSL   = 7'd1 << EV_MSL;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  cfg_index_t            cfg_index = CFG_OWN_ADDRESS;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Percent of cycles in which the sender idles and the receiver stalls.
  int idle_pct = 0;
  int stall_pct = 0;
  int slave_len_set = 0;
  int items_sent = 0;
  int cycle_count = 0;
  int mismatches;
  int pending;

  i2cseq_in_if  feed_ch ();
  i2cseq_out_if result_ch ();

  always #5 clk_i = ~clk_i;

  i2c_transfer_event_sequencer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (feed_ch),
    .out_o       (result_ch)
  );

  i2cseq_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .in_ch        (feed_ch),
    .out_ch       (result_ch),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // The receiver decides at every falling edge whether it takes a result transfer
  // at the next rising edge. With stall_pct at zero it never stalls.
  always @(negedge clk_i) begin
    result_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // A fully random item within the field ranges. Callers overwrite the fields
  // that matter, so the rest still toggles every bit as noise.
  function automatic in_item_t fresh_item();
    in_item_t it;
    it.mode           = mode_t'($urandom_range(3));
    it.event_flags    = 7'($urandom_range(127));
    it.error_flags    = 4'($urandom_range(15));
    it.data_byte      = 8'($urandom_range(255));
    it.read_not_write = 1'($urandom_range(1));
    it.target_address = 7'($urandom_range(127));
    it.byte_count     = 6'($urandom_range(32));
    it.store_select   = 1'($urandom_range(1));
    it.entry_index    = 5'($urandom_range(31));
    return it;
  endfunction

  // Errors show up on a small share of bus events.
  function automatic logic [3:0] some_errors();
    return ($urandom_range(99) < 8) ? 4'($urandom_range(1, 15)) : 4'd0;
  endfunction

  // The bus master flag is usually set while a master transfer runs.
  function automatic logic [6:0] bus_master_bit();
    return ($urandom_range(99) < 80) ? F_MSL : 7'd0;
  endfunction

  // Mostly short master transfers, now and then a full-length one.
  function automatic int pick_count();
    return ($urandom_range(99) < 10) ? 32 : $urandom_range(6);
  endfunction

  // Presents one item and holds it until the transfer completes. The task is entered
  // and left at a falling edge, so valid gets at most one update per time step.
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      feed_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    feed_ch.valid   <= 1'b1;
    feed_ch.payload <= it;
    do @(posedge clk_i); while (!feed_ch.ready);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_event(input logic [6:0] flags, input logic [3:0] errs,
                            input logic [7:0] data);
    in_item_t it;
    it             = fresh_item();
    it.mode        = MODE_EVENT;
    it.event_flags = flags;
    it.error_flags = errs;
    it.data_byte   = data;
    send_item(it);
  endtask

  task automatic send_start(input logic rnw, input int count, input logic [6:0] target);
    in_item_t it;
    it                = fresh_item();
    it.mode           = MODE_START;
    it.read_not_write = rnw;
    it.byte_count     = 6'(count);
    it.target_address = target;
    send_item(it);
  endtask

  task automatic send_load(input logic slave_side, input int idx, input logic [7:0] data);
    in_item_t it;
    it              = fresh_item();
    it.mode         = MODE_LOAD;
    it.store_select = slave_side;
    it.entry_index  = 5'(idx);
    it.data_byte    = data;
    send_item(it);
  endtask

  task automatic send_read(input logic slave_side, input int idx);
    in_item_t it;
    it              = fresh_item();
    it.mode         = MODE_READ;
    it.store_select = slave_side;
    it.entry_index  = 5'(idx);
    send_item(it);
  endtask

  // Stops sending and waits until every expected result has been taken.
  task automatic drain();
    feed_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // One register write; the idle wait after it keeps back-to-back writes apart.
  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  // Master write: start, address phase, then bytes streamed from the master store,
  // possibly past the length. Usually ends with a zero-length read, whose first
  // received byte drops the block back to slave mode.
  task automatic master_write(input int count, input int extra);
    send_start(1'b0, count, 7'($urandom_range(127)));
    send_event(F_SB | bus_master_bit(), some_errors(), 8'($urandom_range(255)));
    send_event(F_ADDR | F_TRA | bus_master_bit(), some_errors(), 8'($urandom_range(255)));
    repeat (count + extra) begin
      send_event(F_TXE | F_TRA | bus_master_bit(), some_errors(), 8'($urandom_range(255)));
    end
    send_event(F_STOPF | bus_master_bit(), some_errors(), 8'($urandom_range(255)));
    if ($urandom_range(3) != 0) begin
      send_start(1'b1, 0, 7'($urandom_range(127)));
      send_event(F_RXNE | bus_master_bit(), some_errors(), 8'($urandom_range(255)));
    end
  endtask

  // Master read: received bytes fill the master store; one byte past the length
  // returns the block to slave mode.
  task automatic master_read(input int count, input int extra);
    send_start(1'b1, count, 7'($urandom_range(127)));
    send_event(F_SB | bus_master_bit(), some_errors(), 8'($urandom_range(255)));
    send_event(F_ADDR | bus_master_bit(), some_errors(), 8'($urandom_range(255)));
    repeat (count + extra) begin
      send_event(F_RXNE | bus_master_bit(), some_errors(), 8'($urandom_range(255)));
    end
  endtask

  task automatic slave_receive(input int n);
    send_event(F_ADDR, some_errors(), 8'($urandom_range(255)));
    repeat (n) send_event(F_RXNE, some_errors(), 8'($urandom_range(255)));
    send_event(F_STOPF, some_errors(), 8'($urandom_range(255)));
  endtask

  task automatic slave_send(input int n);
    send_event(F_ADDR | F_TRA, some_errors(), 8'($urandom_range(255)));
    repeat (n) send_event(F_TXE | F_TRA, some_errors(), 8'($urandom_range(255)));
    send_event(F_STOPF, some_errors(), 8'($urandom_range(255)));
  endtask

  // Watchdog: a hung handshake ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    int             phase_goal;
    int             half_goal;
    int             pick;
    bit             paused;
    logic [6:0]     own_value;

    feed_ch.valid   = 1'b0;
    feed_ch.payload = '0;
    result_ch.ready = 1'b0;

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    write_reg(CFG_OWN_ADDRESS, 7'h2A);
    write_reg(CFG_SLAVE_LENGTH, 7'd2);
    slave_len_set = 2;

    // The byte stores come out of reset undefined, so every entry of both is
    // loaded before anything can read it back.
    for (int s = 0; s < 2; s++) begin
      for (int e = 0; e < 32; e++) send_load(1'(s), e, 8'($urandom_range(255)));
    end

    // Reads at both ends of the stores.
    send_read(1'b0, 0);
    send_read(1'b1, 31);

    // One-byte master write to the highest address: the byte completes the transfer
    // with a stop, the next one streams past the length, then all errors arrive
    // while bus master together with a seen stop.
    send_start(1'b0, 1, 7'h7F);
    send_event(F_SB | F_MSL, 4'd0, 8'h00);
    send_event(F_ADDR | F_TRA | F_MSL, 4'd0, 8'h00);
    send_event(F_TXE | F_TRA | F_MSL, 4'd0, 8'h00);
    send_event(F_TXE | F_TRA | F_MSL, 4'd0, 8'h00);
    send_event(F_STOPF | F_MSL, 4'hF, 8'h00);

    // Zero-length master read: the first byte ends master mode without a stop.
    send_start(1'b1, 0, 7'h00);
    send_event(F_SB | F_MSL, 4'd0, 8'h00);
    send_event(F_RXNE | F_MSL, 4'd0, 8'hFF);

    // Two-byte master read, then a byte past the length.
    send_start(1'b1, 2, 7'h55);
    send_event(F_SB | F_MSL, 4'd0, 8'h00);
    send_event(F_ADDR | F_MSL, 4'd0, 8'h00);
    send_event(F_RXNE | F_MSL, 4'd0, 8'hFF);
    send_event(F_RXNE | F_MSL, 4'd0, 8'h00);
    send_event(F_RXNE | F_MSL, 4'd0, 8'hA5);

    // Slave with a length of two: the third received byte is dropped and the
    // third transmitted byte is zero. Errors without bus master request no stop.
    send_event(F_ADDR, 4'd0, 8'h00);
    send_event(F_RXNE, 4'd0, 8'h11);
    send_event(F_RXNE, 4'd0, 8'h22);
    send_event(F_RXNE, 4'd0, 8'h33);
    send_event(F_ADDR | F_TRA, 4'd0, 8'h00);
    send_event(F_TXE | F_TRA, 4'd0, 8'h00);
    send_event(F_TXE | F_TRA, 4'd0, 8'h00);
    send_event(F_TXE | F_TRA, 4'd0, 8'h00);
    send_event(F_STOPF, 4'b1010, 8'h00);

    // Random phases, each with its own throttling and register settings.
    for (int phase = 0; phase < 4; phase++) begin
      drain();
      case (phase)
        0: begin
          idle_pct      = 0;
          stall_pct     = 0;
          own_value     = 7'h7F;
          slave_len_set = 32;
        end
        1: begin
          idle_pct      = 52;
          stall_pct     = 0;
          own_value     = 7'h00;
          slave_len_set = 0;
        end
        2: begin
          idle_pct      = 0;
          stall_pct     = 52;
          own_value     = 7'($urandom_range(127));
          slave_len_set = $urandom_range(1, 8);
        end
        default: begin
          idle_pct      = 17;
          stall_pct     = 17;
          own_value     = 7'($urandom_range(127));
          slave_len_set = 1;
        end
      endcase
      write_reg(CFG_OWN_ADDRESS, own_value);
      write_reg(CFG_SLAVE_LENGTH, 7'(slave_len_set));

      // A long master write drives the byte position through its wrap at 256,
      // reading past the store end and completing a second time after the wrap.
      if (phase == 0) master_write(32, 260);

      phase_goal = items_sent + ITEMS_PER_PHASE;
      half_goal  = items_sent + ITEMS_PER_PHASE / 2;
      paused     = 1'b0;
      while (items_sent < phase_goal) begin
        // Halfway through, the sender holds off until every result is back.
        if (!paused && items_sent >= half_goal) begin
          drain();
          paused = 1'b1;
        end
        pick = $urandom_range(99);
        if (pick < 25) begin
          master_write(pick_count(), $urandom_range(3));
        end else if (pick < 50) begin
          master_read(pick_count(), $urandom_range(2));
        end else if (pick < 68) begin
          slave_receive($urandom_range(slave_len_set + 2));
        end else if (pick < 84) begin
          slave_send($urandom_range(slave_len_set + 2));
        end else begin
          repeat ($urandom_range(1, 4)) send_item(fresh_item());
        end
      end
    end

    drain();
    repeat (10) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/i2cseq_pkg.sv
rtl/i2cseq_if.sv
rtl/i2cseq_ram.sv
rtl/i2c_transfer_event_sequencer.sv
sim/i2cseq_checker.sv
sim/i2c_transfer_event_sequencer_tb.sv
